@@ design/skal_pkg.sv @@
// Shared types and constants for the three-axis scalar Kalman filter.
package skal_pkg;

  localparam int LANES = 3;
  localparam int SAMPLE_W = 16;
  localparam int EST_W = 24;
  localparam int NOISE_W = 16;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_Q_NOISE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_R_NOISE = 8'd1;

  localparam logic [NOISE_W-1:0] Q_NOISE_RST = 16'd66;
  localparam logic [NOISE_W-1:0] R_NOISE_RST = 16'd6554;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic signed [EST_W-1:0] filtered_x;
    logic signed [EST_W-1:0] filtered_y;
    logic signed [EST_W-1:0] filtered_z;
  } out_item_t;

  // Per-item strobes from the sequencer to every lane.
  typedef struct packed {
    logic mul;
    logic commit;
  } lane_ctl_t;

endpackage

@@ design/skal_div.sv @@
// Restoring divider for the Kalman gain, one quotient bit per cycle.
module skal_div #(
  parameter int VAR_FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [VAR_FRAC_BITS+1:0] num,
  input  logic [VAR_FRAC_BITS+2:0] den,
  output logic                     done,
  output logic [VAR_FRAC_BITS:0]   quot
);
  import skal_pkg::*;

  localparam int VF = VAR_FRAC_BITS;
  localparam int CW = $clog2(VF + 1);

  logic [VF+3:0] rem_r;
  logic [VF+2:0] den_r;
  logic [VF:0]   quot_r;
  logic [CW-1:0] cnt_r;
  logic          active_r;
  logic          done_r;

  logic          ge;
  logic [VF+3:0] diff;

  // The numerator is num scaled by 2^VF; its low bits are all zero, so the
  // remainder just shifts in zeros. num never exceeds den here.
  always_comb begin
    ge   = (rem_r >= {1'b0, den_r});
    diff = ge ? (rem_r - {1'b0, den_r}) : rem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r    <= {2'b00, num};
        den_r    <= den;
        cnt_r    <= '0;
        active_r <= 1'b1;
      end else if (active_r) begin
        rem_r  <= {diff[VF+2:0], 1'b0};
        quot_r <= {quot_r[VF-1:0], ge};
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == CW'(VF)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

@@ design/skal_lane.sv @@
// One axis of the filter: innovation times gain, rounding, saturation.
module skal_lane #(
  parameter int EST_FRAC_BITS = 8,
  parameter int VAR_FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  skal_pkg::lane_ctl_t                ctl,
  input  logic signed [skal_pkg::SAMPLE_W-1:0] sample,
  input  logic [VAR_FRAC_BITS:0]             gain,
  output logic signed [skal_pkg::EST_W-1:0]  est_nxt
);
  import skal_pkg::*;

  localparam int VF = VAR_FRAC_BITS;
  localparam int MW = (SAMPLE_W + EST_FRAC_BITS > EST_W) ? SAMPLE_W + EST_FRAC_BITS : EST_W;
  localparam int DW = MW + 1;
  localparam int PW = DW + VF + 1;
  localparam logic signed [PW:0] SAT_HI = (PW+1)'(8388607);
  localparam logic signed [PW:0] SAT_LO = (PW+1)'(-8388608);

  logic signed [EST_W-1:0] est_r;
  logic signed [PW-1:0]    prod_r;

  logic signed [DW-1:0] meas;
  logic signed [DW-1:0] innov;
  logic signed [PW-1:0] prod;
  logic                 neg;
  logic [PW-1:0]        mag;
  logic [PW-1:0]        corr;
  logic signed [PW:0]   sum;

  always_comb begin
    meas  = DW'(sample) <<< EST_FRAC_BITS;
    innov = meas - DW'(est_r);
    prod  = $signed({1'b0, gain}) * innov;
    // Round the magnitude so that ties go away from zero.
    neg   = prod_r[PW-1];
    mag   = neg ? (PW)'(-prod_r) : prod_r;
    corr  = (mag + (PW)'(1 << (VF - 1))) >> VF;
    sum   = neg ? ((PW+1)'(est_r) - $signed({1'b0, corr}))
                : ((PW+1)'(est_r) + $signed({1'b0, corr}));
    if (sum > SAT_HI) begin
      est_nxt = SAT_HI[EST_W-1:0];
    end else if (sum < SAT_LO) begin
      est_nxt = SAT_LO[EST_W-1:0];
    end else begin
      est_nxt = sum[EST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r <= '0;
    end else if (ctl.commit) begin
      est_r <= est_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_r <= prod;
    end
  end

endmodule

@@ design/scalar_kalman_three_axis_top.sv @@
// Per item: IDLE takes the sample and predicted variance, PRED starts the divider, DIV
// waits for the quotient, MUL forms products, FIN commits once the output can take it.
// Throughput is set by the gain divider, which resolves one quotient bit per cycle.
// A new item is taken while the previous result still waits in the output register.
// Synchronous active-low reset: estimates clear to zero, variance to 1.0,
// Q and R to their default noise values.
module scalar_kalman_three_axis_top #(
  parameter int EST_FRAC_BITS = 8,
  parameter int VAR_FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  skal_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output skal_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [skal_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [skal_pkg::NOISE_W-1:0]       cfg_data
);
  import skal_pkg::*;

  localparam int VF  = VAR_FRAC_BITS;
  localparam int SHL = (VF >= NOISE_W) ? VF - NOISE_W : 0;
  localparam int SHR = (VF <  NOISE_W) ? NOISE_W - VF : 0;
  localparam logic [VF+1:0] VAR_ONE = (VF+2)'(1) << VF;
  localparam logic [VF+1:0] VAR_MAX = '1;

  typedef enum logic [2:0] {ST_IDLE, ST_PRED, ST_DIV, ST_MUL, ST_FIN} state_t;

  state_t             state_r;
  logic [NOISE_W-1:0] q_noise_r;
  logic [NOISE_W-1:0] r_noise_r;
  logic [VF+1:0]      var_r;
  logic [VF+1:0]      p1_r;
  logic [VF:0]        gain_r;
  logic [2*VF+2:0]    pprod_r;
  in_item_t           samp_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [VF+NOISE_W+1:0] q_wide;
  logic [VF+NOISE_W+1:0] r_wide;
  logic [VF+2:0]         p1_sum;
  logic [VF+1:0]         p1_nxt;
  logic [VF+2:0]         den;
  logic                  div_done;
  logic [VF:0]           quot;
  logic [VF:0]           gain_nxt;
  logic [2*VF+3:0]       pn_wide;
  logic [VF+1:0]         var_nxt;
  logic                  fin_go;
  lane_ctl_t             lane_ctl;

  logic signed [SAMPLE_W-1:0] lane_samp [LANES];
  logic signed [EST_W-1:0]    lane_est  [LANES];

  always_comb begin
    q_wide   = ((VF+NOISE_W+2)'(q_noise_r) << SHL) >> SHR;
    r_wide   = ((VF+NOISE_W+2)'(r_noise_r) << SHL) >> SHR;
    p1_sum   = (VF+3)'(var_r) + (VF+3)'(q_wide[VF-1:0]);
    p1_nxt   = p1_sum[VF+2] ? VAR_MAX : p1_sum[VF+1:0];
    den      = (VF+3)'(p1_r) + (VF+3)'(r_wide[VF-1:0]);
    // A zero denominator leaves the quotient all ones, which clamps to 1.0.
    gain_nxt = (quot > VAR_ONE[VF:0]) ? VAR_ONE[VF:0] : quot;
    pn_wide  = ((2*VF+4)'(pprod_r) + (2*VF+4)'(VAR_ONE >> 1)) >> VF;
    var_nxt  = pn_wide[VF+1:0];
    fin_go   = (state_r == ST_FIN) && (!out_valid_r || out_ready);
    lane_ctl.mul    = (state_r == ST_MUL);
    lane_ctl.commit = fin_go;
  end

  assign lane_samp[0] = samp_r.accel_x;
  assign lane_samp[1] = samp_r.accel_y;
  assign lane_samp[2] = samp_r.accel_z;

  skal_div #(
    .VAR_FRAC_BITS(VAR_FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_PRED),
    .num   (p1_r),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    skal_lane #(
      .EST_FRAC_BITS(EST_FRAC_BITS),
      .VAR_FRAC_BITS(VAR_FRAC_BITS)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (lane_ctl),
      .sample  (lane_samp[i]),
      .gain    (gain_r),
      .est_nxt (lane_est[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      q_noise_r   <= Q_NOISE_RST;
      r_noise_r   <= R_NOISE_RST;
      var_r       <= VAR_ONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_Q_NOISE: q_noise_r <= cfg_data;
          CFG_R_NOISE: r_noise_r <= cfg_data;
          default: ;
        endcase
      end
      // A new result may replace the one being taken in the same cycle.
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            samp_r  <= in_data;
            p1_r    <= p1_nxt;
            state_r <= ST_PRED;
          end
        end
        ST_PRED: state_r <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            gain_r  <= gain_nxt;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          pprod_r <= (VAR_ONE[VF:0] - gain_r) * p1_r;
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_go) begin
            var_r                 <= var_nxt;
            out_data_r.filtered_x <= lane_est[0];
            out_data_r.filtered_y <= lane_est[1];
            out_data_r.filtered_z <= lane_est[2];
            state_r               <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

@@ design/skal_checker.sv @@
// Port-level checks for the scalar Kalman filter top level, with its bind.
module skal_props (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input skal_pkg::out_item_t            out_data
);
  import skal_pkg::*;

  // Reset leaves no result pending and the input side open.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("result pending or input closed after reset");

  // An item needs many cycles, so no result can appear right after an accept.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after accept");

  // The block is idle again once it posts a result.
  a_ready_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("input not ready when a new result was posted");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind scalar_kalman_three_axis_top skal_props u_skal_props (.*);
